// ----- design/emsa_pkcs1_v15_encode_verify_defines.svh -----
// Assertion macros shared by the encoder/verifier RTL.
`ifndef EMSA_PKCS1_V15_ENCODE_VERIFY_DEFINES_SVH
`define EMSA_PKCS1_V15_ENCODE_VERIFY_DEFINES_SVH

// Clocked assertion, held off while reset is asserted.
`define EMSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define EMSA_NEVER(label, expr, msg) \
  `EMSA_ASSERT(label, !(expr), msg)

`endif

// ----- design/emsa_pkg.sv -----
// ----------------------------------------------------------------------------
// emsa_pkg
// Shared types, constants and DigestInfo header tables for the encoder.
// ----------------------------------------------------------------------------
package emsa_pkg;

  localparam int unsigned MAX_EM_BYTES = 512;
  localparam int unsigned LEN_W        = $clog2(MAX_EM_BYTES + 1);
  localparam int unsigned EM_LEN_W     = 10;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned FIXED_BYTES  = 11;
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QPTR_W       = $clog2(QDEPTH);
  localparam int unsigned QCNT_W       = $clog2(QDEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_SHA1   = 2'd0,
    KIND_SHA256 = 2'd1,
    KIND_SHA512 = 2'd2,
    KIND_BAD    = 2'd3
  } hash_kind_e;

  typedef enum logic [0:0] {
    REG_HASH_KIND = 1'b0,
    REG_EM_LENGTH = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_KIND  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_PREAMBLE  = 3'd3,
    ST_PAD       = 3'd4,
    ST_SEPARATOR = 3'd5,
    ST_HEADER    = 3'd6,
    ST_HASH      = 3'd7
  } status_e;

  localparam hash_kind_e         HASH_KIND_RST = KIND_SHA256;
  localparam logic [EM_LEN_W-1:0] EM_LENGTH_RST = 10'd256;

  // Classified position handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] exp_byte;
    logic [7:0] rx_byte;
    status_e    code;      // region, or forced status when not normal
    logic       normal;    // configuration is usable
    logic       last;
    logic       first;
    logic       op;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_ok;
    logic       last;
    status_e    status;
  } res_t;

  function automatic logic [6:0] dig_len(hash_kind_e kind);
    unique case (kind)
      KIND_SHA1:   dig_len = 7'd20;
      KIND_SHA256: dig_len = 7'd32;
      KIND_SHA512: dig_len = 7'd64;
      default:     dig_len = 7'd0;
    endcase
  endfunction

  function automatic logic [4:0] der_len(hash_kind_e kind);
    unique case (kind)
      KIND_SHA1:   der_len = 5'd15;
      KIND_SHA256: der_len = 5'd19;
      KIND_SHA512: der_len = 5'd19;
      default:     der_len = 5'd0;
    endcase
  endfunction

  function automatic logic [7:0] der_byte(hash_kind_e kind, logic [4:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      5'd0:  b = 8'h30;
      5'd1:  b = (kind == KIND_SHA1) ? 8'h21 : (kind == KIND_SHA256) ? 8'h31 : 8'h51;
      5'd2:  b = 8'h30;
      5'd3:  b = (kind == KIND_SHA1) ? 8'h09 : 8'h0d;
      5'd4:  b = 8'h06;
      5'd5:  b = (kind == KIND_SHA1) ? 8'h05 : 8'h09;
      5'd6:  b = (kind == KIND_SHA1) ? 8'h2b : 8'h60;
      5'd7:  b = (kind == KIND_SHA1) ? 8'h0e : 8'h86;
      5'd8:  b = (kind == KIND_SHA1) ? 8'h03 : 8'h48;
      5'd9:  b = (kind == KIND_SHA1) ? 8'h02 : 8'h01;
      5'd10: b = (kind == KIND_SHA1) ? 8'h1a : 8'h65;
      5'd11: b = (kind == KIND_SHA1) ? 8'h05 : 8'h03;
      5'd12: b = (kind == KIND_SHA1) ? 8'h00 : 8'h04;
      5'd13: b = (kind == KIND_SHA1) ? 8'h04 : 8'h02;
      5'd14: b = (kind == KIND_SHA1) ? 8'h14 : (kind == KIND_SHA256) ? 8'h01 : 8'h03;
      5'd15: b = (kind == KIND_SHA1) ? 8'h00 : 8'h05;
      5'd16: b = 8'h00;
      5'd17: b = (kind == KIND_SHA1) ? 8'h00 : 8'h04;
      5'd18: b = (kind == KIND_SHA1) ? 8'h00 : (kind == KIND_SHA256) ? 8'h20 : 8'h40;
      default: b = 8'h00;
    endcase
    der_byte = b;
  endfunction

endpackage

// ----- design/emsa_front.sv -----
// ----------------------------------------------------------------------------
// emsa_front
// Position counter and region classifier: works out the expected byte.
// ----------------------------------------------------------------------------
module emsa_front import emsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  hash_kind_e          hash_kind_i,
  input  logic [EM_LEN_W-1:0] em_length_i,
  input  logic                operation_i,
  input  logic [7:0]          em_byte_i,
  input  logic [7:0]          hash_byte_i,
  output item_t               item_o
);

  logic [LEN_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] len;
  logic [LEN_W:0]   pos_inc;
  logic [LEN_W-1:0] hlen, dlen, sep, off;
  logic [LEN_W:0]   min_len;
  logic             last;

  always_comb begin
    if (EM_LEN_W'(em_length_i) > EM_LEN_W'(MAX_EM_BYTES) && EM_LEN_W < LEN_W + 1) begin
      len = LEN_W'(MAX_EM_BYTES);
    end else if ({1'b0, em_length_i} > (EM_LEN_W + 1)'(MAX_EM_BYTES)) begin
      len = LEN_W'(MAX_EM_BYTES);
    end else begin
      len = LEN_W'(em_length_i);
    end
    pos_inc = {1'b0, pos_q} + (LEN_W + 1)'(1);
    last    = (pos_inc >= {1'b0, len});
    hlen    = LEN_W'(dig_len(hash_kind_i));
    dlen    = LEN_W'(der_len(hash_kind_i));
    min_len = (LEN_W + 1)'(FIXED_BYTES) + {1'b0, hlen} + {1'b0, dlen};
    sep     = len - LEN_W'(1) - hlen - dlen;
    off     = pos_q - sep - LEN_W'(1);

    item_o          = '0;
    item_o.rx_byte  = em_byte_i;
    item_o.last     = last;
    item_o.first    = (pos_q == '0);
    item_o.op       = operation_i;
    item_o.normal   = 1'b0;
    item_o.exp_byte = 8'h00;
    item_o.code     = ST_OK;
    priority if (hash_kind_i == KIND_BAD) begin
      item_o.code = ST_BAD_KIND;
    end else if ({1'b0, len} < min_len) begin
      item_o.code = ST_SHORT;
    end else begin
      item_o.normal = 1'b1;
      priority if (pos_q < LEN_W'(2)) begin
        item_o.exp_byte = 8'(pos_q);
        item_o.code     = ST_PREAMBLE;
      end else if (pos_q < sep) begin
        item_o.exp_byte = 8'hff;
        item_o.code     = ST_PAD;
      end else if (pos_q == sep) begin
        item_o.exp_byte = 8'h00;
        item_o.code     = ST_SEPARATOR;
      end else if (off < dlen) begin
        item_o.exp_byte = der_byte(hash_kind_i, off[4:0]);
        item_o.code     = ST_HEADER;
      end else begin
        item_o.exp_byte = hash_byte_i;
        item_o.code     = ST_HASH;
      end
    end
  end

  // Wrap after the last byte, otherwise advance.
  assign pos_d = last ? '0 : pos_inc[LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- design/emsa_queue.sv -----
// ----------------------------------------------------------------------------
// emsa_queue
// Short queue of classified positions between the front and back ends.
// ----------------------------------------------------------------------------
`include "emsa_pkcs1_v15_encode_verify_defines.svh"

module emsa_queue import emsa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  `EMSA_NEVER(a_q_overflow, cnt_q > QCNT_W'(QDEPTH), "queue count beyond depth")
  `EMSA_ASSERT(a_q_fill, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)), "queue count did not advance on push")

endmodule

// ----- design/emsa_back.sv -----
// ----------------------------------------------------------------------------
// emsa_back
// Compare, first-error tracking and a two-entry result buffer.
// ----------------------------------------------------------------------------
`include "emsa_pkcs1_v15_encode_verify_defines.svh"

module emsa_back import emsa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t item_i,
  input  logic  item_empty_i,
  output logic  item_pop_o,
  input  logic  pop_i,
  output logic  empty_o,
  output res_t  res_o
);

  logic    mode_q;
  status_e fe_q;
  logic    mode_eff;
  status_e fe_base, fe_new;
  res_t    res_new;
  res_t    buf0_q, buf1_q;
  logic    v0_q, v1_q;
  logic    take, put;

  // Take a queued position whenever the second buffer slot is free.
  assign put        = ~item_empty_i & ~v1_q;
  assign item_pop_o = put;
  assign take       = pop_i & v0_q;
  assign empty_o    = ~v0_q;
  assign res_o      = buf0_q;

  always_comb begin
    mode_eff         = item_i.first ? item_i.op : mode_q;
    fe_base          = item_i.first ? ST_OK : fe_q;
    fe_new           = fe_base;
    res_new.out_byte = item_i.exp_byte;
    res_new.last     = item_i.last;
    res_new.byte_ok  = 1'b1;
    res_new.status   = ST_OK;
    if (!item_i.normal) begin
      res_new.out_byte = 8'h00;
      res_new.byte_ok  = 1'b0;
      res_new.status   = item_i.code;
    end else if (mode_eff) begin
      res_new.byte_ok = (item_i.rx_byte == item_i.exp_byte);
      if (!res_new.byte_ok && fe_base == ST_OK) begin
        fe_new = item_i.code;
      end
      if (item_i.last) begin
        res_new.status = fe_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      fe_q   <= ST_OK;
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
    end else begin
      if (put) begin
        mode_q <= mode_eff;
        fe_q   <= fe_new;
      end
      if (take) begin
        v0_q <= v1_q | put;
        v1_q <= v1_q & put;
      end else if (put) begin
        v0_q <= 1'b1;
        v1_q <= v0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      buf0_q <= v1_q ? buf1_q : res_new;
      if (v1_q) begin
        buf1_q <= res_new;
      end
    end else if (put) begin
      if (v0_q) begin
        buf1_q <= res_new;
      end else begin
        buf0_q <= res_new;
      end
    end
  end

  `EMSA_ASSERT(a_buf_order, v1_q |-> v0_q, "second result slot filled ahead of the first")
  `EMSA_ASSERT(a_bad_cfg_zero, (v0_q && (buf0_q.status == ST_BAD_KIND || buf0_q.status == ST_SHORT)) |-> (!buf0_q.byte_ok && buf0_q.out_byte == 8'h00), "bad configuration result carries data")

endmodule

// ----- design/emsa_pkcs1_v15_encode_verify.sv -----
// ----------------------------------------------------------------------------
// emsa_pkcs1_v15_encode_verify
// EMSA-PKCS1-v1_5 signature padding, one encoded-message byte per transfer,
// in encode (generate) or verify (compare) mode.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  ---------------------------------
//  input     in         push / full             operation, em_byte, hash_byte
//  result    out        pop / empty             out_byte, byte_ok, last, status
//  config    in         psel/penable/pwrite     hash_kind (0x0), em_length (0x4)
//
//  One transfer in gives one transfer out; a byte may enter every cycle
//  while the queue is not full. The accepting edge writes the queue, and
//  the position then moves on into the result buffer, where empty drops.
//  The front end classifies the position in the push cycle; the queue of
//  four lets it run ahead while the result side is stalled.
//  Reset clears position, mode and the held error; registers return to
//  SHA-256 and a length of 256 bytes.
//
module emsa_pkcs1_v15_encode_verify import emsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  push,
  output logic                  full,
  input  logic                  operation_i,
  input  logic [7:0]            em_byte_i,
  input  logic [7:0]            hash_byte_i,
  // result channel
  input  logic                  pop,
  output logic                  empty,
  output logic [7:0]            out_byte_o,
  output logic                  byte_ok_o,
  output logic                  last_o,
  output logic [2:0]            status_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  hash_kind_e          hash_kind_q;
  logic [EM_LEN_W-1:0] em_length_q;
  reg_idx_e            reg_idx;
  logic                cfg_wr;
  logic                accept;
  item_t               front_item, back_item;
  logic                q_empty, q_pop;
  res_t                res;

  // Configuration registers: one word each, written in the access phase.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      REG_HASH_KIND: prdata = APB_DATA_W'(hash_kind_q);
      REG_EM_LENGTH: prdata = APB_DATA_W'(em_length_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_kind_q <= HASH_KIND_RST;
      em_length_q <= EM_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HASH_KIND: hash_kind_q <= hash_kind_e'(pwdata[KIND_W-1:0]);
        REG_EM_LENGTH: em_length_q <= pwdata[EM_LEN_W-1:0];
        default:       em_length_q <= em_length_q;
      endcase
    end
  end

  // A transfer in happens when the queue has room.
  assign accept = push & ~full;

  emsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .hash_kind_i (hash_kind_q),
    .em_length_i (em_length_q),
    .operation_i (operation_i),
    .em_byte_i   (em_byte_i),
    .hash_byte_i (hash_byte_i),
    .item_o      (front_item)
  );

  // Hold classified positions while the result side stalls.
  emsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .item_o  (back_item),
    .empty_o (q_empty)
  );

  // Compare, track the first error and buffer results for transfer out.
  emsa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_empty_i (q_empty),
    .item_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .res_o        (res)
  );

  assign out_byte_o = res.out_byte;
  assign byte_ok_o  = res.byte_ok;
  assign last_o     = res.last;
  assign status_o   = res.status;

endmodule
